// ===== rtl/ptb_pkg.sv =====
// shared constants and field layout of the pattern trie builder
package ptb_pkg;

    // default table size
    localparam int MAX_STATES_DEF = 1024;
    localparam int ALPHABET_DEF   = 256;

    // field widths
    localparam int BYTE_W = 8;
    localparam int PN_W   = 10;
    localparam int ROW_W  = 10;
    localparam int NS_W   = 10;
    localparam int SU_W   = 11;
    localparam int PC_W   = 10;

    // stream word widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // input tdata layout
    localparam int S_BYTE_LSB = 0;
    localparam int S_PN_LSB   = S_BYTE_LSB + BYTE_W;
    localparam int S_ROW_LSB  = S_PN_LSB + PN_W;
    localparam int S_USED_W   = S_ROW_LSB + ROW_W;

    // output tdata layout
    localparam int M_NS_LSB  = 0;
    localparam int M_VLD_BIT = M_NS_LSB + NS_W;
    localparam int M_OVF_BIT = M_VLD_BIT + 1;
    localparam int M_SU_LSB  = M_OVF_BIT + 1;
    localparam int M_USED_W  = M_SU_LSB + SU_W;

    // command codes carried in s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // reset value of the pattern count
    localparam logic [PC_W-1:0] PC_RESET = PC_W'(1);

endpackage

// ===== rtl/pattern_trie_builder.sv =====
// goto-table builder for a failureless multi-pattern matcher, single memory read-modify-write
// result path: the table read is registered, the look cycle decides, then the result register loads
// one item in flight: a new item is taken only after the table read and write back of the last one
// reset: synchronous active-low aresetn; afterwards a clearing pass writes every table entry,
//   MAX_STATES * 2**clog2(ALPHABET) entries (262144 at defaults), with s_tready low
// configuration writes are taken during the clearing pass as at any other idle time
module pattern_trie_builder #(
    parameter int MAX_STATES = ptb_pkg::MAX_STATES_DEF,
    parameter int ALPHABET   = ptb_pkg::ALPHABET_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: pattern_count
    input  logic                          cfg_wr_en,
    input  logic [ptb_pkg::PC_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata from lsb: pattern_byte[7:0], pattern_number[17:8], read_row[27:18], zero pad
    input  logic [ptb_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: cmd
    input  logic                          s_tuser,
    // tlast: last_byte
    input  logic                          s_tlast,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata from lsb: next_state[9:0], entry_valid[10], overflow[11], states_used[22:12], pad
    output logic [ptb_pkg::M_TDATA_W-1:0] m_tdata
);

    // table geometry: row is the state, column the byte
    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int COL_W   = $clog2(ALPHABET);
    localparam int ADDR_W  = STATE_W + COL_W;
    localparam int DEPTH   = MAX_STATES * (2 ** COL_W);
    // stored value holds a state number or a pattern id
    localparam int VAL_W   = (STATE_W > ptb_pkg::PN_W) ? STATE_W : ptb_pkg::PN_W;
    localparam int ENTRY_W = VAL_W + 1;
    // state counters must hold MAX_STATES and pattern_count + 2
    localparam int NF_W    = (STATE_W + 1 > ptb_pkg::SU_W) ? STATE_W + 1 : ptb_pkg::SU_W;

    localparam logic [NF_W-1:0]              MAX_NF    = NF_W'(MAX_STATES);
    localparam logic [ptb_pkg::BYTE_W:0]     ALPHA_LIM = (ptb_pkg::BYTE_W + 1)'(ALPHABET);
    localparam logic [ADDR_W-1:0]            CLR_LAST  = ADDR_W'(DEPTH - 1);

    // sequencer codes
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]        state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // build state
    logic [ptb_pkg::PC_W-1:0] pc_reg;
    logic [NF_W-1:0]          walk_reg, walk_next;
    logic                     at_start_reg, at_start_next;
    logic [NF_W-1:0]          nf_reg, nf_next;
    logic                     ovf_reg, ovf_next;

    // item held across the read cycle
    logic                       cmd_reg;
    logic [ptb_pkg::BYTE_W-1:0] byte_reg;
    logic                       last_reg;
    logic [ptb_pkg::PN_W-1:0]   pid_reg;
    logic [ptb_pkg::ROW_W-1:0]  row_reg;
    logic [NF_W-1:0]            cur_reg;
    logic [ADDR_W-1:0]          addr_reg;

    // table memory with a registered read
    logic [ENTRY_W-1:0] table_mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // output register
    logic                          m_valid_reg;
    logic [ptb_pkg::M_TDATA_W-1:0] m_data_reg;

    // input field unpacking
    logic [ptb_pkg::BYTE_W-1:0] in_byte;
    logic [ptb_pkg::PN_W-1:0]   in_pid;
    logic [ptb_pkg::ROW_W-1:0]  in_row;
    logic [NF_W-1:0]            root;
    logic [NF_W-1:0]            in_cur;
    logic [NF_W-1:0]            in_row_ext;
    logic [ADDR_W-1:0]          in_addr;
    logic                       in_xfer;

    assign in_byte = s_tdata[ptb_pkg::S_BYTE_LSB +: ptb_pkg::BYTE_W];
    assign in_pid  = s_tdata[ptb_pkg::S_PN_LSB +: ptb_pkg::PN_W];
    assign in_row  = s_tdata[ptb_pkg::S_ROW_LSB +: ptb_pkg::ROW_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // walk starts from the root computed from the current pattern count
    assign root       = NF_W'(pc_reg) + NF_W'(1);
    assign in_cur     = at_start_reg ? root : walk_reg;
    assign in_row_ext = NF_W'(in_row);
    // out-of-range rows and columns wrap here; they are masked off in the look cycle
    assign in_addr = (s_tuser == ptb_pkg::CMD_READ)
                   ? {in_row_ext[STATE_W-1:0], in_byte[COL_W-1:0]}
                   : {in_cur[STATE_W-1:0], in_byte[COL_W-1:0]};

    // look cycle: entry data is here, decide result and write back
    logic               look_done;
    logic               byte_ok;
    logic               row_ok;
    logic               rd_vld;
    logic [VAL_W-1:0]   rd_val;
    logic [VAL_W-1:0]   res_val;
    logic               res_vld;
    logic               look_we;
    logic [ENTRY_W-1:0] look_wdata;

    assign look_done = (state_reg == ST_LOOK) && (!m_valid_reg || m_tready);
    assign byte_ok   = {1'b0, byte_reg} < ALPHA_LIM;
    assign row_ok    = NF_W'(row_reg) < MAX_NF;
    assign rd_vld    = rd_data_reg[VAL_W];
    assign rd_val    = rd_data_reg[VAL_W-1:0];

    always_comb begin
        res_val       = '0;
        res_vld       = 1'b0;
        look_we       = 1'b0;
        look_wdata    = '0;
        walk_next     = walk_reg;
        at_start_next = at_start_reg;
        nf_next       = nf_reg;
        ovf_next      = ovf_reg;
        if (cmd_reg == ptb_pkg::CMD_READ) begin
            if (row_ok && byte_ok && rd_vld) begin
                res_val = rd_val;
                res_vld = 1'b1;
            end
        end else if (!ovf_reg && byte_ok) begin
            if (cur_reg >= MAX_NF) begin
                // walk row lies outside the table
                ovf_next = 1'b1;
            end else if (last_reg) begin
                // final byte points at the pattern id, walk back to the root
                look_we       = 1'b1;
                look_wdata    = {1'b1, VAL_W'(pid_reg)};
                res_val       = VAL_W'(pid_reg);
                res_vld       = 1'b1;
                walk_next     = root;
                at_start_next = 1'b1;
            end else if (rd_vld) begin
                // follow the existing edge
                walk_next     = NF_W'(rd_val);
                at_start_next = 1'b0;
                res_val       = rd_val;
                res_vld       = 1'b1;
            end else if (nf_reg >= MAX_NF) begin
                // no free state left
                ovf_next = 1'b1;
            end else begin
                // allocate a new state
                look_we       = 1'b1;
                look_wdata    = {1'b1, nf_reg[VAL_W-1:0]};
                walk_next     = nf_reg;
                at_start_next = 1'b0;
                nf_next       = nf_reg + NF_W'(1);
                res_val       = nf_reg[VAL_W-1:0];
                res_vld       = 1'b1;
            end
        end
    end

    // memory write port: clearing sweep or look write back
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = look_done && look_we;
            mem_waddr = addr_reg;
            mem_wdata = look_wdata;
        end
    end

    // the write of one item lands before the next item's read, so no forwarding is needed
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (in_xfer) begin
            rd_data_reg <= table_mem[in_addr];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == CLR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (look_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // build state; a configuration write restarts the build
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= ptb_pkg::PC_RESET;
            walk_reg     <= NF_W'(ptb_pkg::PC_RESET) + NF_W'(1);
            at_start_reg <= 1'b1;
            nf_reg       <= NF_W'(ptb_pkg::PC_RESET) + NF_W'(2);
            ovf_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            pc_reg       <= cfg_wr_data;
            walk_reg     <= NF_W'(cfg_wr_data) + NF_W'(1);
            at_start_reg <= 1'b1;
            nf_reg       <= NF_W'(cfg_wr_data) + NF_W'(2);
            ovf_reg      <= 1'b0;
        end else if (look_done) begin
            walk_reg     <= walk_next;
            at_start_reg <= at_start_next;
            nf_reg       <= nf_next;
            ovf_reg      <= ovf_next;
        end
    end

    // item capture at input transfer
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg  <= s_tuser;
            byte_reg <= in_byte;
            last_reg <= s_tlast;
            pid_reg  <= in_pid;
            row_reg  <= in_row;
            cur_reg  <= in_cur;
            addr_reg <= in_addr;
        end
    end

    // result register, loaded as the look cycle completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (look_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (look_done) begin
            m_data_reg <= {1'b0, nf_next[ptb_pkg::SU_W-1:0], ovf_next, res_vld,
                           res_val[ptb_pkg::NS_W-1:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/ptb_checker.sv =====
// port-level checker for the pattern trie builder, bound to the top level
module ptb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptb_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty entry always reports state zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[ptb_pkg::M_VLD_BIT]
        |-> m_tdata[ptb_pkg::M_NS_LSB +: ptb_pkg::NS_W] == '0)
        else $error("empty entry with nonzero state");

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("input taken during table access");

    // a fresh result follows an input transfer, with the look cycle between them
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_xfer, 2))
        else $error("result without a matching input transfer");

endmodule

bind pattern_trie_builder ptb_checker u_ptb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
